// ===== hdl/nbew_pkg.sv =====
// nbew_pkg: shared types and codes for the neighbor edge weight block
// configuration record, operation and register codes, queue entry layout
// no dependencies
package nbew_pkg;

    // fixed width of the pixel and weight fields on the ports
    localparam int unsigned FIELD_W = 16;

    // entries of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_CW    = 3;

    typedef enum logic [1:0] {
        REG_DIRECTION    = 2'd0,
        REG_OPERATION    = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_RANGE  = 2'd0,
        OP_MAXVAL = 2'd1,
        OP_MINVAL = 2'd2
    } op_t;

    localparam logic DIR_RIGHT = 1'b0;
    localparam logic DIR_BELOW = 1'b1;

    localparam logic [12:0] WIDTH_RESET  = 13'd4096;
    localparam logic [15:0] HEIGHT_RESET = 16'd1;

    typedef struct packed {
        logic        direction;
        logic [1:0]  operation;
        logic [12:0] image_width;
        logic [15:0] image_height;
    } cfg_t;

    // one classified pixel: its partner, itself and which results it owes
    typedef struct packed {
        logic [FIELD_W-1:0] partner;
        logic [FIELD_W-1:0] pixel;
        logic               has_pair;
        logic               has_zero;
        logic               is_last;
    } queue_entry_t;

endpackage

// ===== hdl/nbew_front.sv =====
// nbew_front: accepts pixels, tracks column and row, keeps the line store
// and previous pixel, classifies each pixel into a queue entry
// depends on nbew_pkg
module nbew_front #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned PIXEL_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nbew_pkg::cfg_t                cfg,
    input  logic                          accept,
    input  logic [nbew_pkg::FIELD_W-1:0]  pixel,
    output logic                          push,
    output nbew_pkg::queue_entry_t        entry
);

    localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned EW = (CW + 1 > 13) ? CW + 1 : 13;

    logic [CW-1:0]         col_reg;
    logic [CW-1:0]         col_next;
    logic [15:0]           row_reg;
    logic [15:0]           row_next;
    logic [PIXEL_BITS-1:0] prev_reg;
    logic [PIXEL_BITS-1:0] line_rd_reg;
    logic [PIXEL_BITS-1:0] line_mem [MAX_WIDTH];

    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [PIXEL_BITS-1:0] s1_prev_reg;
    logic                  s1_pair_reg;
    logic                  s1_zero_reg;
    logic                  s1_last_reg;

    logic [PIXEL_BITS-1:0] pix;
    logic [EW-1:0]         w_raw;
    logic [EW-1:0]         w_eff;
    logic [15:0]           h_eff;
    logic                  last_col;
    logic                  last_row;
    logic                  has_pair;
    logic                  has_zero;
    logic [PIXEL_BITS-1:0] partner;

    assign pix = pixel[PIXEL_BITS-1:0];

    // width zero acts as one, oversize widths clamp to the store depth
    always_comb
    begin
        w_raw = EW'(cfg.image_width);
        priority if (w_raw == '0)
            w_eff = EW'(1);
        else if (w_raw > EW'(MAX_WIDTH))
            w_eff = EW'(MAX_WIDTH);
        else
            w_eff = w_raw;
        h_eff = (cfg.image_height == '0) ? 16'd1 : cfg.image_height;
    end

    assign last_col = (EW'(col_reg) + EW'(1)) >= w_eff;
    assign last_row = ({1'b0, row_reg} + 17'd1) >= {1'b0, h_eff};

    always_comb
    begin
        if (cfg.direction == nbew_pkg::DIR_RIGHT)
        begin
            has_pair = (col_reg != '0);
            has_zero = last_col;
        end
        else
        begin
            has_pair = (row_reg != '0);
            has_zero = last_row;
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 16'd1;
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept && (has_pair || has_zero);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_reg <= '0;
        else if (accept)
            prev_reg <= pix;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pix;
            s1_prev_reg <= prev_reg;
            s1_pair_reg <= has_pair;
            s1_zero_reg <= has_zero;
            s1_last_reg <= last_col && last_row;
        end
    end

    // line store, read before write at the current column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_rd_reg       <= line_mem[col_reg];
            line_mem[col_reg] <= pix;
        end
    end

    assign partner = (cfg.direction == nbew_pkg::DIR_RIGHT) ? s1_prev_reg : line_rd_reg;

    assign push           = s1_valid_reg;
    assign entry.partner  = nbew_pkg::FIELD_W'(partner);
    assign entry.pixel    = nbew_pkg::FIELD_W'(s1_pix_reg);
    assign entry.has_pair = s1_pair_reg;
    assign entry.has_zero = s1_zero_reg;
    assign entry.is_last  = s1_last_reg;

    // the final pixel of the image returns both counters to the origin
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_col && last_row) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not wrap after the final pixel");

endmodule

// ===== hdl/nbew_queue.sv =====
// nbew_queue: short queue of classified pixels between front and back
// depends on nbew_pkg
module nbew_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  nbew_pkg::queue_entry_t              push_entry,
    input  logic                                pop,
    output logic                                head_valid,
    output nbew_pkg::queue_entry_t              head,
    output logic [nbew_pkg::QUEUE_CW-1:0]       count
);

    nbew_pkg::queue_entry_t             slot_reg [nbew_pkg::QUEUE_DEPTH];
    logic [nbew_pkg::QUEUE_AW-1:0]      wr_ptr_reg;
    logic [nbew_pkg::QUEUE_AW-1:0]      rd_ptr_reg;
    logic [nbew_pkg::QUEUE_CW-1:0]      count_reg;
    logic [nbew_pkg::QUEUE_CW-1:0]      count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + nbew_pkg::QUEUE_CW'(1);
        else if (pop && !push)
            count_next = count_reg - nbew_pkg::QUEUE_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + nbew_pkg::QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + nbew_pkg::QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != nbew_pkg::QUEUE_CW'(nbew_pkg::QUEUE_DEPTH)) || pop)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule

// ===== hdl/nbew_back.sv =====
// nbew_back: combines pixel pairs and issues weights and border zeros
// into the output register
// depends on nbew_pkg
module nbew_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [1:0]                          operation,
    input  logic                                head_valid,
    input  nbew_pkg::queue_entry_t              head,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [nbew_pkg::FIELD_W-1:0]        weight,
    output logic                                last
);

    logic                           phase_reg;
    logic                           phase_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [nbew_pkg::FIELD_W-1:0]   weight_reg;
    logic [nbew_pkg::FIELD_W-1:0]   weight_next;
    logic                           last_reg;
    logic                           last_next;
    logic [nbew_pkg::FIELD_W-1:0]   combined;
    logic                           load;
    logic                           issue;
    logic                           pair_now;

    // unused operation code falls through to minimum
    always_comb
    begin
        priority if (operation == nbew_pkg::OP_RANGE)
            combined = (head.partner > head.pixel) ? head.partner - head.pixel
                                                   : head.pixel - head.partner;
        else if (operation == nbew_pkg::OP_MAXVAL)
            combined = (head.partner > head.pixel) ? head.partner : head.pixel;
        else
            combined = (head.partner < head.pixel) ? head.partner : head.pixel;
    end

    assign load     = !out_valid_reg || out_ready;
    assign issue    = head_valid && load;
    assign pair_now = head.has_pair && !phase_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        weight_next    = weight_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (load)
            out_valid_next = head_valid;
        if (issue)
        begin
            if (pair_now)
            begin
                weight_next = combined;
                last_next   = 1'b0;
                phase_next  = head.has_zero;
                pop         = !head.has_zero;
            end
            else
            begin
                // border pixel, carries the end-of-image mark
                weight_next = '0;
                last_next   = head.is_last;
                phase_next  = 1'b0;
                pop         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign weight    = weight_reg;
    assign last      = last_reg;

    // second half of a two-result entry waits at the head of the queue
    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (head_valid && head.has_pair && head.has_zero))
        else $error("second result pending without a matching entry");

endmodule

// ===== hdl/neighbor_edge_weight.sv =====
// neighbor_edge_weight: top level, configuration registers and the
// front, queue and back parts of the edge weight stream
// depends on nbew_pkg, nbew_front, nbew_queue, nbew_back
//
// usage
//   pixels come in raster order on in_valid/in_ready/pixel, one request
//   per pixel; each pixel is paired with its right neighbor or with the
//   pixel below it and the pair gives one weight (absolute difference,
//   maximum or minimum); border pixels give a zero weight
//   weights leave on out_valid/out_ready/weight/last, last marks the final
//   weight of the image
//   a result passes the front stage and line store read, a queue slot and
//   the output register after the request that completes its pair
//   throughput is one pixel per cycle while in_ready is high; a pixel owing
//   two results (a pair weight and a border zero) holds the back end for
//   both; the queue soaks up row ends, a vertical last row runs at half rate
//   the configuration port writes one register per cycle with cfg_write,
//   cfg_index and cfg_data, and is meant to change only between images
//   reset clears the counters, the queue and the output register, and sets
//   direction right, operation absolute difference, width 4096, height 1;
//   the line store is not cleared, each row writes what the next one reads
//   when out_ready is low the output register holds, the queue fills and
//   in_ready drops once queue entries plus the front stage reach four
module neighbor_edge_weight #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned PIXEL_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [nbew_pkg::FIELD_W-1:0]  pixel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [nbew_pkg::FIELD_W-1:0]  weight,
    output logic                          last
);

    nbew_pkg::cfg_t                  cfg_reg;
    nbew_pkg::cfg_t                  cfg_next;
    logic                            in_accept;
    logic                            push;
    nbew_pkg::queue_entry_t          entry;
    logic                            pop;
    logic                            head_valid;
    nbew_pkg::queue_entry_t          head;
    logic [nbew_pkg::QUEUE_CW-1:0]   count;
    logic [nbew_pkg::QUEUE_CW:0]     occupancy;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (nbew_pkg::reg_index_t'(cfg_index))
                nbew_pkg::REG_DIRECTION:    cfg_next.direction    = cfg_data[0];
                nbew_pkg::REG_OPERATION:    cfg_next.operation    = cfg_data[1:0];
                nbew_pkg::REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[12:0];
                nbew_pkg::REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction    <= nbew_pkg::DIR_RIGHT;
            cfg_reg.operation    <= nbew_pkg::OP_RANGE;
            cfg_reg.image_width  <= nbew_pkg::WIDTH_RESET;
            cfg_reg.image_height <= nbew_pkg::HEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // credit check: queue entries plus the one in the front stage
    assign occupancy = {1'b0, count} + (nbew_pkg::QUEUE_CW + 1)'(push);
    assign in_ready  = occupancy < (nbew_pkg::QUEUE_CW + 1)'(nbew_pkg::QUEUE_DEPTH);
    assign in_accept = in_valid && in_ready;

    nbew_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .accept (in_accept),
        .pixel  (pixel),
        .push   (push),
        .entry  (entry)
    );

    nbew_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (count)
    );

    nbew_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .operation  (cfg_reg.operation),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .weight     (weight),
        .last       (last)
    );

endmodule
